>>> hdl/iptfc_pkg.sv
// Package for the IPv4 TCP flow classifier: request and response payload types,
// flow key and table control structs, header check and status constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iptfc_pkg;

	localparam logic [1:0] KIND_ADD      = 2'd0;
	localparam logic [1:0] KIND_REMOVE   = 2'd1;
	localparam logic [1:0] KIND_CLASSIFY = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_MISS      = 3'd1;
	localparam logic [2:0] ST_SLOW      = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	localparam logic [15:0] ETH_HDR_BYTES    = 16'd14;
	localparam logic [15:0] IPV4_MIN_HDR_LEN = 16'd20;
	localparam logic [15:0] MIN_FRAME_LEN    = ETH_HDR_BYTES + IPV4_MIN_HDR_LEN;
	localparam logic [15:0] ETYPE_IPV4       = 16'h0800;
	localparam logic [3:0]  IP_MIN_IHL       = 4'd5;
	localparam logic [7:0]  PROTO_TCP        = 8'd6;
	localparam logic [15:0] IP_DF            = 16'h4000;
	localparam logic [7:0]  TH_FIN_SYN_RST   = 8'h07;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] frame_len;
		logic [15:0] ethertype;
		logic [3:0]  ip_ihl;
		logic [7:0]  ip_proto;
		logic [15:0] frag_word;
		logic [7:0]  tcp_flags;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_tcp_port;
		logic [15:0] dst_tcp_port;
		logic [7:0]  channel_id;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] out_channel;
	} rsp_t;

	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_tcp_port;
		logic [15:0] dst_tcp_port;
	} flow_key_t;

	// lookup summary from the table
	typedef struct packed {
		logic       hit;
		logic       free_avail;
		logic [7:0] channel;
	} lookup_t;

	// table update command; the entry select travels beside it
	typedef struct packed {
		logic       wr_en;
		logic       set_valid;
		logic [7:0] channel;
	} table_wr_t;

endpackage

`default_nettype wire

>>> hdl/iptfc_flow_table.sv
// Flow table: per-entry valid bits, keys and channels with a parallel key compare.
// Depends on iptfc_pkg for the key, lookup and write command types.
`timescale 1ns / 1ps
`default_nettype none

module iptfc_flow_table #(
	parameter int FLOW_ENTRIES = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  iptfc_pkg::flow_key_t        lookup_key,
	output iptfc_pkg::lookup_t          lookup,
	output logic [FLOW_ENTRIES-1:0]     hit_sel,
	output logic [FLOW_ENTRIES-1:0]     free_sel,
	input  iptfc_pkg::table_wr_t        wr,
	input  wire  [FLOW_ENTRIES-1:0]     wr_sel
);

	logic [FLOW_ENTRIES-1:0] valid_q;
	iptfc_pkg::flow_key_t    key_q  [FLOW_ENTRIES];
	logic [7:0]              chan_q [FLOW_ENTRIES];

	logic [FLOW_ENTRIES-1:0] match;
	logic [FLOW_ENTRIES-1:0] empty;
	logic [7:0]              chan_or;

	always_comb begin
		for (int i = 0; i < FLOW_ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == lookup_key);
		end
	end

	assign empty = ~valid_q;

	// isolate lowest set bit
	assign hit_sel  = match & (~match + {{(FLOW_ENTRIES-1){1'b0}}, 1'b1});
	assign free_sel = empty & (~empty + {{(FLOW_ENTRIES-1){1'b0}}, 1'b1});

	always_comb begin
		chan_or = '0;
		for (int i = 0; i < FLOW_ENTRIES; i++) begin
			chan_or = chan_or | (chan_q[i] & {8{hit_sel[i]}});
		end
	end

	assign lookup.hit        = |match;
	assign lookup.free_avail = |empty;
	assign lookup.channel    = chan_or;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.wr_en) begin
			for (int i = 0; i < FLOW_ENTRIES; i++) begin
				if (wr_sel[i]) begin
					valid_q[i] <= wr.set_valid;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.wr_en && wr.set_valid) begin
			for (int i = 0; i < FLOW_ENTRIES; i++) begin
				if (wr_sel[i]) begin
					key_q[i]  <= lookup_key;
					chan_q[i] <= wr.channel;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/ipv4_tcp_flow_classifier.sv
// IPv4 TCP flow classifier top level: input register, header checks, result register.
// Depends on iptfc_pkg and iptfc_flow_table.
//
// Usage:
//   req/req_valid/req_ready carry one add, remove or classify transaction each.
//   rsp/rsp_valid/rsp_ready return exactly one status transaction per request,
//   in request order.
//   A request is captured in an input register; from there the header
//   checks, the parallel compare across all FLOW_ENTRIES keys and the table
//   update run in one pass and the answer lands in the response register.
//   Between request accept and rsp_valid lie the input and response
//   registers; one request per cycle is sustained without stalls, limited by
//   the combinational key compare and the table write the next request sees.
//   When the receiver stalls the response register holds, the input register
//   fills, and req_ready drops until the response is taken.
//   Reset clears all flow valid bits at once, so the table starts empty with
//   no clearing pass; both registers come up empty.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_tcp_flow_classifier #(
	parameter int FLOW_ENTRIES = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_ready,
	input  iptfc_pkg::req_t    req,
	output logic               rsp_valid,
	input  wire                rsp_ready,
	output iptfc_pkg::rsp_t    rsp
);

	logic                    valid_s1;
	iptfc_pkg::req_t         req_s1;
	logic                    rsp_valid_q;
	iptfc_pkg::rsp_t         rsp_q;

	logic                    advance;
	iptfc_pkg::flow_key_t    key;
	iptfc_pkg::lookup_t      lookup;
	logic [FLOW_ENTRIES-1:0] hit_sel;
	logic [FLOW_ENTRIES-1:0] free_sel;
	iptfc_pkg::table_wr_t    wr;
	logic [FLOW_ENTRIES-1:0] wr_sel;
	iptfc_pkg::rsp_t         result;
	logic                    fast_ok;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign key.src_ip       = req_s1.src_ip;
	assign key.dst_ip       = req_s1.dst_ip;
	assign key.src_tcp_port = req_s1.src_tcp_port;
	assign key.dst_tcp_port = req_s1.dst_tcp_port;

	iptfc_flow_table #(
		.FLOW_ENTRIES(FLOW_ENTRIES)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.lookup_key(key),
		.lookup    (lookup),
		.hit_sel   (hit_sel),
		.free_sel  (free_sel),
		.wr        (wr),
		.wr_sel    (wr_sel)
	);

	// frame must hold the Ethernet header plus a minimal IPv4 header
	assign fast_ok = (req_s1.frame_len >= iptfc_pkg::MIN_FRAME_LEN) &&
		(req_s1.ethertype == iptfc_pkg::ETYPE_IPV4) &&
		(req_s1.ip_ihl >= iptfc_pkg::IP_MIN_IHL) &&
		(req_s1.ip_proto == iptfc_pkg::PROTO_TCP) &&
		((req_s1.frag_word & ~iptfc_pkg::IP_DF) == 16'd0) &&
		((req_s1.tcp_flags & iptfc_pkg::TH_FIN_SYN_RST) == 8'd0);

	always_comb begin
		result.status      = iptfc_pkg::ST_SLOW;
		result.out_channel = 8'd0;
		wr.wr_en           = 1'b0;
		wr.set_valid       = 1'b0;
		wr.channel         = req_s1.channel_id;
		wr_sel             = hit_sel;
		case (req_s1.kind)
			iptfc_pkg::KIND_ADD: begin
				wr.set_valid = 1'b1;
				if (lookup.hit) begin
					wr.wr_en      = advance;
					result.status = iptfc_pkg::ST_OK;
				end else if (lookup.free_avail) begin
					wr.wr_en      = advance;
					wr_sel        = free_sel;
					result.status = iptfc_pkg::ST_OK;
				end else begin
					result.status = iptfc_pkg::ST_FULL;
				end
			end
			iptfc_pkg::KIND_REMOVE: begin
				if (lookup.hit) begin
					wr.wr_en      = advance;
					result.status = iptfc_pkg::ST_OK;
				end else begin
					result.status = iptfc_pkg::ST_NOT_FOUND;
				end
			end
			iptfc_pkg::KIND_CLASSIFY: begin
				if (fast_ok) begin
					if (lookup.hit) begin
						result.status      = iptfc_pkg::ST_OK;
						result.out_channel = lookup.channel;
					end else begin
						result.status = iptfc_pkg::ST_MISS;
					end
				end
			end
			default: begin
				result.status = iptfc_pkg::ST_SLOW;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q <= result;
		end
	end

endmodule

`default_nettype wire
